FILE: src/srarq_pkg.sv
// Shared types, constants and helpers for the selective-repeat ARQ endpoint.
// No dependencies.
package srarq_pkg;

	localparam int SEQ_W = 3;
	localparam int SLOT_W = 2;
	localparam int PAY_W = 32;
	localparam int NRB = 4;
	localparam logic [SEQ_W-1:0] SEQ_MAX = 3'd7;

	localparam logic [2:0] REQ_NEW = 3'd0;
	localparam logic [2:0] REQ_FRAME = 3'd1;
	localparam logic [2:0] REQ_CKSUM = 3'd2;
	localparam logic [2:0] REQ_TIMEOUT = 3'd3;
	localparam logic [2:0] REQ_ACKTO = 3'd4;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ACK = 2'd1;
	localparam logic [1:0] KIND_NAK = 2'd2;

	localparam logic [1:0] OUT_TX = 2'd0;
	localparam logic [1:0] OUT_DELIVER = 2'd1;
	localparam logic [1:0] OUT_STOP = 2'd2;
	localparam logic [1:0] OUT_STATUS = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic [1:0] rx_kind;
		logic [2:0] rx_seq;
		logic [2:0] rx_ack;
		logic [31:0] data_word;
		logic [2:0] expired_seq;
	} req_t;

	typedef struct packed {
		logic [1:0] out_type;
		logic [1:0] tx_kind;
		logic [2:0] tx_seq;
		logic [2:0] tx_ack;
		logic [31:0] payload_out;
		logic [1:0] timer_slot;
		logic timer_start;
		logic ack_timer_stop;
		logic net_enable;
		logic rejected;
		logic last;
	} res_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;
		logic new_pkt;
		logic rx_data;
		logic deliver;
		logic ack_stop;
		logic emit_tx;
		logic commit;
		logic [1:0] tx_kind;
		logic tx_from_req;
		logic tx_nak_retx;
		logic ack_pop;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		req_t req;
		logic full;
		logic nak_allowed;
		logic rseq_is_low;
		logic rx_accept;
		logic deliver_ready;
		logic nak_retx_ok;
		logic ack_pending;
	} sts_t;

	function automatic logic [SEQ_W-1:0] wrap_inc(input logic [SEQ_W-1:0] v);
		return (v == SEQ_MAX) ? '0 : v + 3'd1;
	endfunction

	function automatic logic in_window(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
			input logic [SEQ_W-1:0] c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

endpackage

FILE: src/srarq_dp.sv
// Datapath of the ARQ endpoint: window edges, arrival map, packet buffers, result word.
// Depends on srarq_pkg.
module srarq_dp (
	input  logic clk,
	input  logic arst_n,
	input  srarq_pkg::req_t req_in,
	input  srarq_pkg::cmd_t cmd,
	output srarq_pkg::sts_t sts,
	output srarq_pkg::res_t res
);
	srarq_pkg::req_t req_q;
	logic [2:0] snd_lo_q, snd_nx_q, rcv_lo_q, rcv_hi_q, cnt_q;
	logic nak_ok_q, stopflag_q, rej_q;
	logic [3:0] amap_q;
	logic [31:0] outb_q [4];
	logic [31:0] inb_q [4];
	logic [2:0] tx_seq;
	logic [2:0] nak_s;

	assign nak_s = srarq_pkg::wrap_inc(req_q.rx_ack);
	always_comb begin
		if (cmd.tx_from_req) tx_seq = req_q.expired_seq;
		else if (cmd.tx_nak_retx) tx_seq = nak_s;
		else tx_seq = snd_nx_q;
	end

	assign sts.req = req_q;
	assign sts.full = cnt_q >= 3'(srarq_pkg::NRB);
	assign sts.nak_allowed = nak_ok_q;
	assign sts.rseq_is_low = req_q.rx_seq == rcv_lo_q;
	assign sts.rx_accept = srarq_pkg::in_window(rcv_lo_q, req_q.rx_seq, rcv_hi_q)
		&& !amap_q[req_q.rx_seq[1:0]];
	assign sts.deliver_ready = amap_q[rcv_lo_q[1:0]];
	assign sts.nak_retx_ok = srarq_pkg::in_window(snd_lo_q, nak_s, snd_nx_q);
	assign sts.ack_pending = srarq_pkg::in_window(snd_lo_q, req_q.rx_ack, snd_nx_q);

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req_in;
		if (cmd.new_pkt && !sts.full) outb_q[snd_nx_q[1:0]] <= req_q.data_word;
		if (cmd.rx_data) inb_q[req_q.rx_seq[1:0]] <= req_q.data_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snd_lo_q <= '0;
			snd_nx_q <= '0;
			rcv_lo_q <= '0;
			rcv_hi_q <= 3'(srarq_pkg::NRB);
			cnt_q <= '0;
			nak_ok_q <= 1'b1;
			amap_q <= '0;
			stopflag_q <= 1'b0;
			rej_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				stopflag_q <= 1'b0;
				rej_q <= 1'b0;
			end
			if (cmd.new_pkt) begin
				if (sts.full) rej_q <= 1'b1;
				else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (cmd.emit_tx && cmd.commit && cmd.tx_kind == srarq_pkg::KIND_DATA
					&& !cmd.tx_from_req && !cmd.tx_nak_retx)
				snd_nx_q <= srarq_pkg::wrap_inc(snd_nx_q);
			if (cmd.emit_tx && cmd.commit && cmd.tx_kind == srarq_pkg::KIND_NAK)
				nak_ok_q <= 1'b0;
			if (cmd.ack_stop) stopflag_q <= 1'b1;
			if (cmd.rx_data) amap_q[req_q.rx_seq[1:0]] <= 1'b1;
			if (cmd.deliver && cmd.commit) begin
				nak_ok_q <= 1'b1;
				amap_q[rcv_lo_q[1:0]] <= 1'b0;
				rcv_lo_q <= srarq_pkg::wrap_inc(rcv_lo_q);
				rcv_hi_q <= srarq_pkg::wrap_inc(rcv_hi_q);
			end
			if (cmd.ack_pop && cmd.commit) begin
				if (cnt_q != 3'd0) cnt_q <= cnt_q - 3'd1;
				snd_lo_q <= srarq_pkg::wrap_inc(snd_lo_q);
			end
		end
	end

	always_comb begin
		res = '0;
		if (cmd.emit_tx) begin
			res.out_type = srarq_pkg::OUT_TX;
			res.tx_kind = cmd.tx_kind;
			res.tx_ack = rcv_lo_q + srarq_pkg::SEQ_MAX;
			res.ack_timer_stop = 1'b1;
			if (cmd.tx_kind == srarq_pkg::KIND_DATA) begin
				res.tx_seq = tx_seq;
				res.payload_out = outb_q[tx_seq[1:0]];
				res.timer_slot = tx_seq[1:0];
				res.timer_start = 1'b1;
			end
		end else if (cmd.deliver) begin
			res.out_type = srarq_pkg::OUT_DELIVER;
			res.payload_out = inb_q[rcv_lo_q[1:0]];
			res.ack_timer_stop = 1'b1;
		end else if (cmd.ack_pop) begin
			res.out_type = srarq_pkg::OUT_STOP;
			res.timer_slot = snd_lo_q[1:0];
		end else begin
			res.out_type = srarq_pkg::OUT_STATUS;
			res.ack_timer_stop = stopflag_q;
			res.net_enable = !sts.full;
			res.rejected = rej_q;
			res.last = 1'b1;
		end
	end
endmodule

FILE: src/srarq_ctrl.sv
// Controller of the ARQ endpoint: sequences one event into its result words.
// Depends on srarq_pkg.
module srarq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	input  srarq_pkg::sts_t sts,
	output srarq_pkg::cmd_t cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_WAIT_TX = 3'd2;
	localparam logic [2:0] ST_DELIVER = 3'd3;
	localparam logic [2:0] ST_NAKRETX = 3'd4;
	localparam logic [2:0] ST_ACKPOP = 3'd5;
	localparam logic [2:0] ST_STATUS = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] guard_q, guard_d;
	srarq_pkg::cmd_t pcmd_q, pcmd_d;
	logic [2:0] after_q, after_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		guard_d = guard_q;
		pcmd_d = pcmd_q;
		after_d = after_q;
		cmd = '0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_d = ST_STATUS;
				pcmd_d = '0;
				pcmd_d.emit_tx = 1'b1;
				case (sts.req.req_type)
					srarq_pkg::REQ_NEW: begin
						cmd.new_pkt = 1'b1;
						if (!sts.full) begin
							state_d = ST_WAIT_TX;
							after_d = ST_STATUS;
						end
					end
					srarq_pkg::REQ_FRAME: begin
						guard_d = '0;
						after_d = (sts.req.rx_kind == srarq_pkg::KIND_NAK) ? ST_NAKRETX : ST_ACKPOP;
						state_d = after_d;
						if (sts.req.rx_kind == srarq_pkg::KIND_DATA) begin
							if (sts.rx_accept) cmd.rx_data = 1'b1;
							if (!sts.rseq_is_low && sts.nak_allowed) begin
								pcmd_d.tx_kind = srarq_pkg::KIND_NAK;
								state_d = ST_WAIT_TX;
								after_d = sts.rx_accept ? ST_DELIVER : after_d;
							end else begin
								cmd.ack_stop = 1'b1;
								if (sts.rx_accept) state_d = ST_DELIVER;
							end
						end
					end
					srarq_pkg::REQ_CKSUM: begin
						if (sts.nak_allowed) begin
							pcmd_d.tx_kind = srarq_pkg::KIND_NAK;
							state_d = ST_WAIT_TX;
							after_d = ST_STATUS;
						end
					end
					srarq_pkg::REQ_TIMEOUT: begin
						pcmd_d.tx_from_req = 1'b1;
						state_d = ST_WAIT_TX;
						after_d = ST_STATUS;
					end
					srarq_pkg::REQ_ACKTO: begin
						pcmd_d.tx_kind = srarq_pkg::KIND_ACK;
						state_d = ST_WAIT_TX;
						after_d = ST_STATUS;
					end
					default: state_d = ST_STATUS;
				endcase
			end
			ST_WAIT_TX: begin
				out_valid = 1'b1;
				cmd.emit_tx = 1'b1;
				cmd.commit = out_ready;
				cmd.tx_kind = pcmd_q.tx_kind;
				cmd.tx_from_req = pcmd_q.tx_from_req;
				cmd.tx_nak_retx = pcmd_q.tx_nak_retx;
				if (out_ready) state_d = after_q;
			end
			ST_DELIVER: begin
				if (sts.deliver_ready && guard_q < 3'(srarq_pkg::NRB)) begin
					out_valid = 1'b1;
					cmd.deliver = 1'b1;
					cmd.commit = out_ready;
					if (out_ready) guard_d = guard_q + 3'd1;
				end else begin
					guard_d = '0;
					state_d = ST_ACKPOP;
				end
			end
			ST_NAKRETX: begin
				if (sts.nak_retx_ok) begin
					pcmd_d = '0;
					pcmd_d.emit_tx = 1'b1;
					pcmd_d.tx_nak_retx = 1'b1;
					after_d = ST_ACKPOP;
					state_d = ST_WAIT_TX;
				end else state_d = ST_ACKPOP;
				guard_d = '0;
			end
			ST_ACKPOP: begin
				if (sts.ack_pending && guard_q < 3'(srarq_pkg::NRB)) begin
					out_valid = 1'b1;
					cmd.ack_pop = 1'b1;
					cmd.commit = out_ready;
					if (out_ready) guard_d = guard_q + 3'd1;
				end else state_d = ST_STATUS;
			end
			ST_STATUS: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			guard_q <= '0;
			pcmd_q <= '0;
			after_q <= ST_STATUS;
		end else begin
			state_q <= state_d;
			guard_q <= guard_d;
			pcmd_q <= pcmd_d;
			after_q <= after_d;
		end
	end

`ifndef SYNTHESIS
	a_guard: assert property (@(posedge clk) disable iff (!arst_n)
		guard_q <= 3'(srarq_pkg::NRB)) else $error("loop guard overrun");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_tx, cmd.deliver, cmd.ack_pop})) else $error("two items at once");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("output while idle");
`endif
endmodule

FILE: src/selective_repeat_arq_endpoint_top.sv
// Top level of the selective-repeat ARQ endpoint.
// Depends on srarq_pkg, srarq_ctrl, srarq_dp.
//  channel  dir  fields
//  s_axis   in   tuser=req_type; tdata=rx_kind,rx_seq,rx_ack,data_word,expired_seq
//  m_axis   out  tuser=out_type; tdata=tx_kind..rejected; tlast=last
// The controller sequences one event at a time; deliveries and acks walk up to four slots.
// arst_n clears window state; buffers need no clearing. Output stalls hold the sequencer.
module selective_repeat_arq_endpoint_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [2:0] s_axis_tuser,   // req_type
	input  logic [47:0] s_axis_tdata,  // rx_kind, rx_seq, rx_ack, data_word, expired_seq
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [1:0] m_axis_tuser,   // out_type
	// tx_kind, tx_seq, tx_ack, payload_out, timer_slot, timer_start, ack_timer_stop,
	// net_enable, rejected
	output logic [47:0] m_axis_tdata,
	output logic m_axis_tlast
);
	srarq_pkg::req_t req;
	srarq_pkg::cmd_t cmd;
	srarq_pkg::sts_t sts;
	srarq_pkg::res_t res;

	assign req.req_type = s_axis_tuser;
	assign req.rx_kind = s_axis_tdata[1:0];
	assign req.rx_seq = s_axis_tdata[4:2];
	assign req.rx_ack = s_axis_tdata[7:5];
	assign req.data_word = s_axis_tdata[39:8];
	assign req.expired_seq = s_axis_tdata[42:40];

	srarq_ctrl u_ctrl (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .sts, .cmd);

	srarq_dp u_dp (.clk, .arst_n, .req_in(req), .cmd, .sts, .res);

	assign m_axis_tuser = res.out_type;
	assign m_axis_tlast = res.last;
	assign m_axis_tdata = {2'b00, res.rejected, res.net_enable,
		res.ack_timer_stop, res.timer_start, res.timer_slot, res.payload_out, res.tx_ack,
		res.tx_seq, res.tx_kind};
endmodule

FILE: tb/selective_repeat_arq_endpoint_checker.sv
// Checker for the selective-repeat ARQ endpoint: watches both stream channels,
// predicts the result words of every accepted request word and compares them.
// Depends on srarq_pkg.
module selective_repeat_arq_endpoint_checker
	import srarq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [2:0] s_axis_tuser,
	input  logic [47:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [1:0] m_axis_tuser,
	input  logic [47:0] m_axis_tdata,
	input  logic m_axis_tlast,
	output int err_count,
	output int pending
);

	logic [2:0] snd_lo, snd_nx, rcv_lo, rcv_hi, nbuf;
	logic nak_ok;
	logic [3:0] arrived;
	logic [31:0] out_buf [4];
	logic [31:0] in_buf [4];
	res_t want_q [$];

	function automatic logic seq_between(input logic [2:0] a, input logic [2:0] b,
			input logic [2:0] c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

	task automatic push_frame(input logic [1:0] kind, input logic [2:0] seq);
		res_t r;
		r = '0;
		r.out_type = OUT_TX;
		r.tx_kind = kind;
		r.tx_seq = seq;
		r.tx_ack = rcv_lo + SEQ_MAX;
		if (kind == KIND_DATA) begin
			r.payload_out = out_buf[seq[1:0]];
			r.timer_slot = seq[1:0];
			r.timer_start = 1'b1;
		end
		r.ack_timer_stop = 1'b1;
		if (kind == KIND_NAK)
			nak_ok = 1'b0;
		want_q.push_back(r);
	endtask

	task automatic predict_event(input req_t q);
		res_t r;
		logic refused, ack_flag;
		logic [2:0] nak_seq;
		int guard;
		refused = 1'b0;
		ack_flag = 1'b0;
		case (q.req_type)
			REQ_NEW: begin
				if (nbuf >= NRB) begin
					refused = 1'b1;
				end else begin
					nbuf = nbuf + 3'd1;
					out_buf[snd_nx[1:0]] = q.data_word;
					push_frame(KIND_DATA, snd_nx);
					snd_nx = snd_nx + 3'd1;
				end
			end
			REQ_FRAME: begin
				if (q.rx_kind == KIND_DATA) begin
					if (q.rx_seq != rcv_lo && nak_ok)
						push_frame(KIND_NAK, 3'd0);
					else
						ack_flag = 1'b1;
					if (seq_between(rcv_lo, q.rx_seq, rcv_hi) && !arrived[q.rx_seq[1:0]]) begin
						arrived[q.rx_seq[1:0]] = 1'b1;
						in_buf[q.rx_seq[1:0]] = q.data_word;
						guard = 0;
						while (arrived[rcv_lo[1:0]] && guard < NRB) begin
							r = '0;
							r.out_type = OUT_DELIVER;
							r.payload_out = in_buf[rcv_lo[1:0]];
							r.ack_timer_stop = 1'b1;
							want_q.push_back(r);
							nak_ok = 1'b1;
							arrived[rcv_lo[1:0]] = 1'b0;
							rcv_lo = rcv_lo + 3'd1;
							rcv_hi = rcv_hi + 3'd1;
							guard++;
						end
					end
				end
				if (q.rx_kind == KIND_NAK) begin
					nak_seq = q.rx_ack + 3'd1;
					if (seq_between(snd_lo, nak_seq, snd_nx))
						push_frame(KIND_DATA, nak_seq);
				end
				guard = 0;
				while (seq_between(snd_lo, q.rx_ack, snd_nx) && guard < NRB) begin
					if (nbuf > 0)
						nbuf = nbuf - 3'd1;
					r = '0;
					r.out_type = OUT_STOP;
					r.timer_slot = snd_lo[1:0];
					want_q.push_back(r);
					snd_lo = snd_lo + 3'd1;
					guard++;
				end
			end
			REQ_CKSUM: begin
				if (nak_ok)
					push_frame(KIND_NAK, 3'd0);
			end
			REQ_TIMEOUT: push_frame(KIND_DATA, q.expired_seq);
			REQ_ACKTO: push_frame(KIND_ACK, 3'd0);
			default: ;
		endcase
		r = '0;
		r.out_type = OUT_STATUS;
		r.ack_timer_stop = ack_flag;
		r.net_enable = (nbuf < NRB);
		r.rejected = refused;
		r.last = 1'b1;
		want_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		req_t q;
		res_t got, want;
		if (!arst_n) begin
			snd_lo = '0;
			snd_nx = '0;
			rcv_lo = '0;
			rcv_hi = 3'(NRB);
			nbuf = '0;
			nak_ok = 1'b1;
			arrived = '0;
			want_q.delete();
			err_count <= 0;
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				q.req_type = s_axis_tuser;
				q.rx_kind = s_axis_tdata[1:0];
				q.rx_seq = s_axis_tdata[4:2];
				q.rx_ack = s_axis_tdata[7:5];
				q.data_word = s_axis_tdata[39:8];
				q.expired_seq = s_axis_tdata[42:40];
				predict_event(q);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.out_type = m_axis_tuser;
				got.tx_kind = m_axis_tdata[1:0];
				got.tx_seq = m_axis_tdata[4:2];
				got.tx_ack = m_axis_tdata[7:5];
				got.payload_out = m_axis_tdata[39:8];
				got.timer_slot = m_axis_tdata[41:40];
				got.timer_start = m_axis_tdata[42];
				got.ack_timer_stop = m_axis_tdata[43];
				got.net_enable = m_axis_tdata[44];
				got.rejected = m_axis_tdata[45];
				got.last = m_axis_tlast;
				if (want_q.size() == 0) begin
					if (err_count < 10)
						$display("unexpected result word: %p", got);
					err_count <= err_count + 1;
				end else begin
					want = want_q.pop_front();
					if (got.out_type !== want.out_type || got.tx_kind !== want.tx_kind
							|| got.tx_seq !== want.tx_seq || got.tx_ack !== want.tx_ack
							|| got.payload_out !== want.payload_out
							|| got.timer_slot !== want.timer_slot
							|| got.timer_start !== want.timer_start
							|| got.ack_timer_stop !== want.ack_timer_stop
							|| got.net_enable !== want.net_enable
							|| got.rejected !== want.rejected || got.last !== want.last) begin
						if (err_count < 10)
							$display("result mismatch: expected %p actual %p", want, got);
						err_count <= err_count + 1;
					end
				end
			end
			pending <= want_q.size();
		end
	end

endmodule

FILE: tb/selective_repeat_arq_endpoint_top_tb.sv
// Testbench top for the selective-repeat ARQ endpoint: clock, reset, request
// stimulus, random output stalls, watchdog and verdict.
// Depends on srarq_pkg, selective_repeat_arq_endpoint_top and its checker.
module selective_repeat_arq_endpoint_top_tb;
	import srarq_pkg::*;

	localparam int STALL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [2:0] s_axis_tuser = '0;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [1:0] m_axis_tuser;
	logic [47:0] m_axis_tdata;
	logic m_axis_tlast;
	logic calm = 1'b0;
	int err_count, pending, idle_cycles;
	logic [2:0] peer_seq, sent_cnt;

	always #2 clk = ~clk;

	selective_repeat_arq_endpoint_top i_dut (.*);

	selective_repeat_arq_endpoint_checker i_chk (.*);

	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 27);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_word(input logic [2:0] req, input logic [1:0] kind,
			input logic [2:0] seq, input logic [2:0] ack, input logic [31:0] word,
			input logic [2:0] expd);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {5'b0, expd, word, ack, seq, kind};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (!calm && $urandom_range(99) < 27) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	task automatic send_random();
		int pick;
		logic [1:0] kind;
		logic [2:0] seq;
		pick = $urandom_range(99);
		if (pick < 32) begin
			send_word(REQ_NEW, 2'($urandom), 3'($urandom), 3'($urandom), $urandom,
				3'($urandom));
			sent_cnt = sent_cnt + 3'd1;
		end else if (pick < 78) begin
			kind = 2'($urandom_range(99) < 55 ? KIND_DATA : 2'($urandom));
			seq = 3'($urandom);
			if (kind == KIND_DATA && $urandom_range(99) < 75) begin
				seq = peer_seq;
				peer_seq = peer_seq + 3'd1;
			end
			send_word(REQ_FRAME, kind, seq, sent_cnt - 3'd1 - 3'($urandom_range(3)),
				$urandom, 3'($urandom));
		end else if (pick < 86) begin
			send_word(REQ_CKSUM, 2'($urandom), 3'($urandom), 3'($urandom), $urandom,
				3'($urandom));
		end else if (pick < 93) begin
			send_word(REQ_TIMEOUT, 2'($urandom), 3'($urandom), 3'($urandom), $urandom,
				3'($urandom));
		end else if (pick < 97) begin
			send_word(REQ_ACKTO, 2'($urandom), 3'($urandom), 3'($urandom), $urandom,
				3'($urandom));
		end else begin
			send_word(3'($urandom_range(5, 7)), 2'($urandom), 3'($urandom), 3'($urandom),
				$urandom, 3'($urandom));
		end
	endtask

	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// fill all four outbound slots, then overflow the window
		send_word(REQ_NEW, 2'd0, 3'd0, 3'd0, 32'h0000_0000, 3'd0);
		send_word(REQ_NEW, 2'd3, 3'd7, 3'd7, 32'hFFFF_FFFF, 3'd7);
		send_word(REQ_NEW, 2'd0, 3'd0, 3'd0, 32'hA5A5_5A5A, 3'd0);
		send_word(REQ_NEW, 2'd0, 3'd0, 3'd0, 32'h1234_5678, 3'd0);
		send_word(REQ_NEW, 2'd0, 3'd0, 3'd0, 32'hDEAD_BEEF, 3'd0);
		send_word(REQ_CKSUM, 2'd0, 3'd0, 3'd0, 32'h0, 3'd0);
		send_word(REQ_CKSUM, 2'd0, 3'd0, 3'd0, 32'h0, 3'd0);
		send_word(REQ_ACKTO, 2'd0, 3'd0, 3'd0, 32'h0, 3'd0);
		send_word(REQ_TIMEOUT, 2'd0, 3'd0, 3'd0, 32'h0, 3'd0);
		send_word(REQ_TIMEOUT, 2'd0, 3'd0, 3'd0, 32'h0, 3'd7);
		send_word(REQ_FRAME, KIND_ACK, 3'd0, 3'd1, 32'h0, 3'd0);
		send_word(REQ_FRAME, KIND_NAK, 3'd0, 3'd1, 32'h0, 3'd0);
		send_word(REQ_FRAME, KIND_DATA, 3'd0, 3'd7, 32'hFFFF_FFFF, 3'd0);
		send_word(REQ_FRAME, KIND_DATA, 3'd2, 3'd7, 32'h0000_0002, 3'd0);
		send_word(REQ_FRAME, KIND_DATA, 3'd1, 3'd7, 32'h0000_0001, 3'd0);
		send_word(REQ_FRAME, KIND_DATA, 3'd7, 3'd7, 32'h0000_0007, 3'd0);
		send_word(REQ_FRAME, 2'd3, 3'd0, 3'd3, 32'h0, 3'd0);
		send_word(3'd5, 2'd0, 3'd0, 3'd0, 32'h0, 3'd0);
		send_word(3'd6, 2'd0, 3'd0, 3'd0, 32'h0, 3'd0);
		send_word(3'd7, 2'd3, 3'd7, 3'd7, 32'hFFFF_FFFF, 3'd7);
		peer_seq = 3'd3;
		sent_cnt = 3'd4;
		for (int n = 0; n < 90; n++) begin
			if (n == 40)
				calm <= 1'b1;
			if (n == 70)
				calm <= 1'b0;
			if (n == 55) begin
				// hold off until every expected word has drained
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			send_random();
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: selective_repeat_arq_endpoint_top.f
src/srarq_pkg.sv
src/srarq_dp.sv
src/srarq_ctrl.sv
src/selective_repeat_arq_endpoint_top.sv
tb/selective_repeat_arq_endpoint_checker.sv
tb/selective_repeat_arq_endpoint_top_tb.sv
